### hw/rtl/thp_pkg.sv
package thp_pkg;

    typedef logic signed [31:0] t_s32;
    typedef logic signed [63:0] t_s64;

    // status that rides along with the pressure quotient
    typedef struct packed {
        logic signed [31:0] temp;
        logic [13:0]        hum;
        logic               nz;
        logic               neg;
    } t_carry;

    // register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_TEMP_CALIB    = 3'd0;
    localparam logic [2:0] REG_PRESS_CALIB_A = 3'd1;
    localparam logic [2:0] REG_PRESS_CALIB_B = 3'd2;
    localparam logic [2:0] REG_PRESS_CALIB_C = 3'd3;
    localparam logic [2:0] REG_HUM_CALIB_A   = 3'd4;
    localparam logic [2:0] REG_HUM_CALIB_B   = 3'd5;

    localparam t_s32 C_T_ROUND   = 32'sd128;
    localparam t_s32 C_H_OFFSET  = 32'sd76800;
    localparam t_s32 C_H_ROUND   = 32'sd16384;
    localparam t_s32 C_H_BIAS    = 32'sd32768;
    localparam t_s32 C_H_BIAS2   = 32'sd2097152;
    localparam t_s32 C_H_ROUND2  = 32'sd8192;
    localparam t_s32 C_H_MAX     = 32'sd419430400;

    localparam logic signed [33:0] C_P_OFFSET = 34'sd128000;
    localparam logic [20:0]        C_P_FULL   = 21'd1048576;
    localparam t_s64               C_P_SCALE  = 64'sd3125;
    localparam t_s64               C_P_BIAS   = 64'sh0000_8000_0000_0000;

    localparam int DIV_STEPS = 64;

endpackage

### hw/rtl/thp_sensor_compensation.sv
// Climate sensor compensation: raw pressure / temperature / humidity words in,
// temperature (0.01 degC), pressure (Pa) and humidity (0.01 %RH) out.
// Input channel: i_in_valid / o_in_stall with the three raw fields; a word is
// taken at an edge with valid high and stall low. Output channel: o_out_valid /
// i_out_stall with the four result fields, one result word per input word.
// Calibration words are written over the APB port (64-bit data, register i at
// byte address 8*i); write them only while no word is in flight.
// Throughput: one word per cycle while o_in_stall is low. The depth is set by
// the pressure division, a restoring divider with one quotient bit per stage
// (64 stages), plus 12 stages of multiply/add ahead of it and 5 behind it.
// The pipeline moves as a whole; a skid register behind the output register
// catches the word that is in the last stage when the receiver stalls, and
// o_in_stall rises only while that skid register is full. Nothing is lost or
// repeated under stall.
// Reset clears all valid bits, including the output and skid valid flags, and
// all calibration registers; the output and skid data registers are not reset.
module thp_sensor_compensation
    import thp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [19:0] i_raw_pressure,
    input  logic [19:0] i_raw_temperature,
    input  logic [15:0] i_raw_humidity,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_temperature_centi,
    output logic [23:0] o_pressure_pa,
    output logic        o_pressure_valid,
    output logic [13:0] o_humidity_centi,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // ---------------- configuration ----------------
    logic [47:0] r_tcal;
    logic [63:0] r_pcal_a;
    logic [63:0] r_pcal_b;
    logic [15:0] r_pcal_c;
    logic [31:0] r_hcal_a;
    logic [39:0] r_hcal_b;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcal   <= '0;
            r_pcal_a <= '0;
            r_pcal_b <= '0;
            r_pcal_c <= '0;
            r_hcal_a <= '0;
            r_hcal_b <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[5:3])
                REG_TEMP_CALIB:    r_tcal   <= pwdata[47:0];
                REG_PRESS_CALIB_A: r_pcal_a <= pwdata;
                REG_PRESS_CALIB_B: r_pcal_b <= pwdata;
                REG_PRESS_CALIB_C: r_pcal_c <= pwdata[15:0];
                REG_HUM_CALIB_A:   r_hcal_a <= pwdata[31:0];
                REG_HUM_CALIB_B:   r_hcal_b <= pwdata[39:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            REG_TEMP_CALIB:    prdata = {16'b0, r_tcal};
            REG_PRESS_CALIB_A: prdata = r_pcal_a;
            REG_PRESS_CALIB_B: prdata = r_pcal_b;
            REG_PRESS_CALIB_C: prdata = {48'b0, r_pcal_c};
            REG_HUM_CALIB_A:   prdata = {32'b0, r_hcal_a};
            REG_HUM_CALIB_B:   prdata = {24'b0, r_hcal_b};
            default:           prdata = '0;
        endcase
    end

    // coefficient fields
    t_s32 t1, t2, t3;
    t_s64 p1, p3, p4, p6, p7, p8, p9;
    logic signed [15:0] p2, p5;
    t_s32 h1, h2, h3, h4, h5, h6;

    assign t1 = {16'b0, r_tcal[15:0]};
    assign t2 = {{16{r_tcal[31]}}, r_tcal[31:16]};
    assign t3 = {{16{r_tcal[47]}}, r_tcal[47:32]};
    assign p1 = {48'b0, r_pcal_a[15:0]};
    assign p2 = r_pcal_a[31:16];
    assign p3 = {{48{r_pcal_a[47]}}, r_pcal_a[47:32]};
    assign p4 = {{48{r_pcal_a[63]}}, r_pcal_a[63:48]};
    assign p5 = r_pcal_b[15:0];
    assign p6 = {{48{r_pcal_b[31]}}, r_pcal_b[31:16]};
    assign p7 = {{48{r_pcal_b[47]}}, r_pcal_b[47:32]};
    assign p8 = {{48{r_pcal_b[63]}}, r_pcal_b[63:48]};
    assign p9 = {{48{r_pcal_c[15]}}, r_pcal_c};
    assign h1 = {24'b0, r_hcal_a[7:0]};
    assign h2 = {{16{r_hcal_a[23]}}, r_hcal_a[23:8]};
    assign h3 = {24'b0, r_hcal_a[31:24]};
    assign h4 = {{16{r_hcal_b[15]}}, r_hcal_b[15:0]};
    assign h5 = {{16{r_hcal_b[31]}}, r_hcal_b[31:16]};
    assign h6 = {{24{r_hcal_b[39]}}, r_hcal_b[39:32]};

    // ---------------- pipeline control ----------------
    logic        adv;
    logic        r_vld [1:81];
    logic        r_skv;
    logic        r_ov;

    assign adv        = !r_skv;
    assign o_in_stall = r_skv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 81; k++) r_vld[k] <= 1'b0;
        end else if (adv) begin
            r_vld[1] <= i_in_valid;
            for (int k = 2; k <= 81; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // ---------------- stages 1..12 ----------------
    logic [19:0] r_rp_d [1:9];
    logic [19:0] r1_rt;
    logic [15:0] r_rh_d [1:6];
    t_s32 r_temp_d [5:11];
    t_s32 r2_m1, r2_dd, r3_v1, r3_m3, r4_tf, r5_hx;
    logic signed [33:0] r5_a;
    t_s64 r6_aa;
    logic signed [49:0] r6_ap5, r6_ap2, r7_ap5, r7_ap2;
    t_s32 r6_h5x, r6_xh6, r6_xh3;
    t_s64 r7_b1, r7_c3, r8_b, r8_a2, r9_a3, r9_b, r10_div, r10_np, r11_num, r11_div;
    t_s32 r7_ha, r7_hb0, r8_ha, r8_hb, r9_x2, r10_x2, r10_ss, r11_x2, r11_m;

    t_s32 s1_x1, s1_d, s4_t5, s6_ha, s8_hbf, s9_s, s11_x3;
    logic signed [67:0] s5_aa;
    logic signed [49:0] s5_ap5, s5_ap2;
    t_s64 s7_ap5, s7_ap2;
    logic [20:0] s9_pd;
    logic [63:0] s11_ma, s11_mb;
    logic [28:0] s11_hx;
    logic [23:0] s11_hs;

    assign s1_x1  = t_s32'({15'b0, r1_rt[19:3]}) - (t1 <<< 1);
    assign s1_d   = t_s32'({16'b0, r1_rt[19:4]}) - t1;
    assign s4_t5  = (r4_tf <<< 2) + r4_tf + C_T_ROUND;
    assign s5_aa  = r5_a * r5_a;
    assign s5_ap5 = r5_a * p5;
    assign s5_ap2 = r5_a * p2;
    assign s6_ha  = t_s32'({2'b0, r_rh_d[6], 14'b0}) - (h4 <<< 20) - r6_h5x + C_H_ROUND;
    assign s7_ap5 = {{14{r7_ap5[49]}}, r7_ap5};
    assign s7_ap2 = {{14{r7_ap2[49]}}, r7_ap2};
    assign s8_hbf = (r8_hb + C_H_ROUND2) >>> 14;
    assign s9_pd  = C_P_FULL - {1'b0, r_rp_d[9]};
    assign s9_s   = r9_x2 >>> 15;
    assign s11_ma = r11_num[63] ? 64'(-r11_num) : 64'(r11_num);
    assign s11_mb = r11_div[63] ? 64'(-r11_div) : 64'(r11_div);
    assign s11_x3 = r11_x2 - (r11_m >>> 4);

    always_comb begin
        if (s11_x3[31]) begin
            s11_hx = '0;
        end else if (s11_x3 > C_H_MAX) begin
            s11_hx = C_H_MAX[28:0];
        end else begin
            s11_hx = s11_x3[28:0];
        end
    end

    assign s11_hs = {7'b0, s11_hx[28:12]} * 24'd100;

    // divider, one quotient bit per stage
    logic [63:0] r_rem [0:DIV_STEPS];
    logic [63:0] r_dq  [0:DIV_STEPS];
    logic [63:0] r_mb  [0:DIV_STEPS];
    t_carry      r_cr  [0:DIV_STEPS];
    logic [63:0] w_nrem [0:DIV_STEPS-1];
    logic        w_ge   [0:DIV_STEPS-1];

    always_comb begin
        logic [64:0] sh;
        logic [64:0] df;
        for (int k = 0; k < DIV_STEPS; k++) begin
            sh        = {r_rem[k], r_dq[k][63]};
            df        = sh - {1'b0, r_mb[k]};
            w_ge[k]   = !df[64];
            w_nrem[k] = w_ge[k] ? df[63:0] : sh[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // stage 1
            r_rp_d[1] <= i_raw_pressure;
            r1_rt     <= i_raw_temperature;
            r_rh_d[1] <= i_raw_humidity;
            for (int k = 2; k <= 9; k++) r_rp_d[k] <= r_rp_d[k-1];
            for (int k = 2; k <= 6; k++) r_rh_d[k] <= r_rh_d[k-1];
            // temperature
            r2_m1 <= s1_x1 * t2;
            r2_dd <= s1_d * s1_d;
            r3_v1 <= r2_m1 >>> 11;
            r3_m3 <= (r2_dd >>> 12) * t3;
            r4_tf <= r3_v1 + (r3_m3 >>> 14);
            r_temp_d[5] <= s4_t5 >>> 8;
            for (int k = 6; k <= 11; k++) r_temp_d[k] <= r_temp_d[k-1];
            r5_a  <= {{2{r4_tf[31]}}, r4_tf} - C_P_OFFSET;
            r5_hx <= r4_tf - C_H_OFFSET;
            // pressure divisor and dividend
            r6_aa   <= s5_aa[63:0];
            r6_ap5  <= s5_ap5;
            r6_ap2  <= s5_ap2;
            r7_b1   <= r6_aa * p6;
            r7_c3   <= r6_aa * p3;
            r7_ap5  <= r6_ap5;
            r7_ap2  <= r6_ap2;
            r8_b    <= r7_b1 + (s7_ap5 <<< 17) + (p4 <<< 35);
            r8_a2   <= (r7_c3 >>> 8) + (s7_ap2 <<< 12);
            r9_a3   <= (r8_a2 + C_P_BIAS) * p1;
            r9_b    <= r8_b;
            r10_div <= r9_a3 >>> 33;
            r10_np  <= t_s64'({12'b0, s9_pd, 31'b0}) - r9_b;
            r11_num <= r10_np * C_P_SCALE;
            r11_div <= r10_div;
            // humidity
            r6_h5x <= h5 * r5_hx;
            r6_xh6 <= r5_hx * h6;
            r6_xh3 <= r5_hx * h3;
            r7_ha  <= s6_ha >>> 15;
            r7_hb0 <= (r6_xh6 >>> 10) * ((r6_xh3 >>> 11) + C_H_BIAS);
            r8_ha  <= r7_ha;
            r8_hb  <= ((r7_hb0 >>> 10) + C_H_BIAS2) * h2;
            r9_x2  <= r8_ha * s8_hbf;
            r10_ss <= s9_s * s9_s;
            r10_x2 <= r9_x2;
            r11_m  <= (r10_ss >>> 7) * h1;
            r11_x2 <= r10_x2;
            // stage 12: divider entry
            r_rem[0]     <= '0;
            r_dq[0]      <= s11_ma;
            r_mb[0]      <= s11_mb;
            r_cr[0].temp <= r_temp_d[11];
            r_cr[0].hum  <= s11_hs[23:10];
            r_cr[0].nz   <= (r11_div != '0);
            r_cr[0].neg  <= r11_num[63] ^ r11_div[63];
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_rem[k+1] <= w_nrem[k];
                r_dq[k+1]  <= {r_dq[k][62:0], w_ge[k]};
                r_mb[k+1]  <= r_mb[k];
                r_cr[k+1]  <= r_cr[k];
            end
        end
    end

    // ---------------- stages 77..81: pressure correction ----------------
    t_s64   r77_p, r78_p, r79_p, r80_p, r81_sum;
    t_s64   r78_p8p, r79_p8p, r80_p8p, r80_c1, r79_qsq;
    logic [63:0] r78_ll;
    logic [31:0] r78_lh;
    t_carry r77_cr, r78_cr, r79_cr, r80_cr, r81_cr;
    t_s64   s77_q;

    assign s77_q = r77_p >>> 13;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r77_p   <= r_cr[DIV_STEPS].neg ? t_s64'(-r_dq[DIV_STEPS])
                                           : t_s64'(r_dq[DIV_STEPS]);
            r77_cr  <= r_cr[DIV_STEPS];
            r78_ll  <= {32'b0, s77_q[31:0]} * {32'b0, s77_q[31:0]};
            r78_lh  <= s77_q[31:0] * s77_q[63:32];
            r78_p8p <= r77_p * p8;
            r78_p   <= r77_p;
            r78_cr  <= r77_cr;
            r79_qsq <= r78_ll + {r78_lh[30:0], 33'b0};
            r79_p   <= r78_p;
            r79_p8p <= r78_p8p;
            r79_cr  <= r78_cr;
            r80_c1  <= r79_qsq * p9;
            r80_p   <= r79_p;
            r80_p8p <= r79_p8p;
            r80_cr  <= r79_cr;
            r81_sum <= r80_p + (r80_c1 >>> 25) + (r80_p8p >>> 19);
            r81_cr  <= r80_cr;
        end
    end

    // ---------------- output register and skid ----------------
    t_s64        s81_pf;
    logic [23:0] s81_press;
    logic [31:0] r_o_temp, r_sk_temp;
    logic [23:0] r_o_press, r_sk_press;
    logic        r_o_pv, r_sk_pv;
    logic [13:0] r_o_hum, r_sk_hum;

    assign s81_pf    = (r81_sum >>> 8) + (p7 <<< 4);
    assign s81_press = r81_cr.nz ? s81_pf[31:8] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_skv <= 1'b0;
        end else if (!r_ov || !i_out_stall) begin
            if (r_skv) begin
                r_ov  <= 1'b1;
                r_skv <= 1'b0;
            end else begin
                r_ov  <= r_vld[81];
            end
        end else if (!r_skv && r_vld[81]) begin
            r_skv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || !i_out_stall) begin
            if (r_skv) begin
                r_o_temp  <= r_sk_temp;
                r_o_press <= r_sk_press;
                r_o_pv    <= r_sk_pv;
                r_o_hum   <= r_sk_hum;
            end else begin
                r_o_temp  <= r81_cr.temp;
                r_o_press <= s81_press;
                r_o_pv    <= r81_cr.nz;
                r_o_hum   <= r81_cr.hum;
            end
        end else if (!r_skv) begin
            r_sk_temp  <= r81_cr.temp;
            r_sk_press <= s81_press;
            r_sk_pv    <= r81_cr.nz;
            r_sk_hum   <= r81_cr.hum;
        end
    end

    assign o_out_valid         = r_ov;
    assign o_temperature_centi = r_o_temp;
    assign o_pressure_pa       = r_o_press;
    assign o_pressure_valid    = r_o_pv;
    assign o_humidity_centi    = r_o_hum;

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import thp_pkg::*;

    localparam int N_RANDOM = 800;
    localparam int LATENCY = 81;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [19:0] rp;
        logic [19:0] rt;
        logic [15:0] rh;
    } t_raw;

    typedef struct packed {
        logic [31:0] temp;
        logic [23:0] press;
        logic        pvalid;
        logic [13:0] hum;
    } t_comp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [19:0] i_raw_pressure;
    logic [19:0] i_raw_temperature;
    logic [15:0] i_raw_humidity;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_temperature_centi;
    logic [23:0] o_pressure_pa;
    logic        o_pressure_valid;
    logic [13:0] o_humidity_centi;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    thp_sensor_compensation DUT (.*);

    // calibration shadow
    logic [47:0] cal_t;
    logic [63:0] cal_pa, cal_pb;
    logic [15:0] cal_pc;
    logic [31:0] cal_ha;
    logic [39:0] cal_hb;

    t_raw  pending_words[$];
    t_comp expected_comp[$];
    bit    failed = 0;
    int    send_gap = 0;
    int    recv_gap = 0;
    int    hold_left = 0;
    int    idle_cycles = 0;
    bit    hold_req = 0;
    bit    sender_pause = 0;

    initial i_clk = 0;
    always #10 i_clk = ~i_clk;

    function automatic t_comp compensate(t_raw w);
        logic signed [31:0] t1, t2, t3, v1, v2, tf, d, temp;
        logic signed [31:0] h1, h2, h3, h4, h5, h6, x, ha, hb, s;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p, q, c1, c2, num;
        logic [63:0] ma, mb, uq;
        t_comp r;
        t1 = {16'd0, cal_t[15:0]};
        t2 = {{16{cal_t[31]}}, cal_t[31:16]};
        t3 = {{16{cal_t[47]}}, cal_t[47:32]};
        v1 = ($signed({12'd0, w.rt} >> 3) - (t1 <<< 1)) * t2;
        v1 = v1 >>> 11;
        d = $signed({12'd0, w.rt} >> 4) - t1;
        v2 = d * d;
        v2 = v2 >>> 12;
        v2 = v2 * t3;
        v2 = v2 >>> 14;
        tf = v1 + v2;
        temp = tf * 5 + 128;
        r.temp = temp >>> 8;

        p1 = {48'd0, cal_pa[15:0]};
        p2 = {{48{cal_pa[31]}}, cal_pa[31:16]};
        p3 = {{48{cal_pa[47]}}, cal_pa[47:32]};
        p4 = {{48{cal_pa[63]}}, cal_pa[63:48]};
        p5 = {{48{cal_pb[15]}}, cal_pb[15:0]};
        p6 = {{48{cal_pb[31]}}, cal_pb[31:16]};
        p7 = {{48{cal_pb[47]}}, cal_pb[47:32]};
        p8 = {{48{cal_pb[63]}}, cal_pb[63:48]};
        p9 = {{48{cal_pc[15]}}, cal_pc};
        a = {{32{tf[31]}}, tf} - 64'sd128000;
        b = a * a * p6;
        b = b + ((a * p5) <<< 17);
        b = b + (p4 <<< 35);
        c1 = a * a * p3;
        a = (c1 >>> 8) + ((a * p2) <<< 12);
        a = ((64'sd1 <<< 47) + a) * p1;
        a = a >>> 33;
        r.press = '0;
        r.pvalid = 1'b0;
        if (a != 0) begin
            p = 64'sd1048576 - $signed({44'd0, w.rp});
            num = ((p <<< 31) - b) * 64'sd3125;
            ma = num[63] ? -num : num;
            mb = a[63] ? -a : a;
            uq = ma / mb;
            p = (num[63] ^ a[63]) ? -$signed(uq) : $signed(uq);
            q = p >>> 13;
            c1 = p9 * q * q;
            c1 = c1 >>> 25;
            c2 = p8 * p;
            c2 = c2 >>> 19;
            p = p + c1 + c2;
            p = (p >>> 8) + (p7 <<< 4);
            r.press = p[31:8];
            r.pvalid = 1'b1;
        end

        h1 = {24'd0, cal_ha[7:0]};
        h2 = {{16{cal_ha[23]}}, cal_ha[23:8]};
        h3 = {24'd0, cal_ha[31:24]};
        h4 = {{16{cal_hb[15]}}, cal_hb[15:0]};
        h5 = {{16{cal_hb[31]}}, cal_hb[31:16]};
        h6 = {{24{cal_hb[39]}}, cal_hb[39:32]};
        x = tf - 32'sd76800;
        ha = ($signed({16'd0, w.rh}) <<< 14) - (h4 <<< 20) - h5 * x + 32'sd16384;
        ha = ha >>> 15;
        hb = x * h6;
        s = x * h3;
        s = s >>> 11;
        hb = (hb >>> 10) * (s + 32'sd32768);
        hb = ((hb >>> 10) + 32'sd2097152) * h2 + 32'sd8192;
        hb = hb >>> 14;
        x = ha * hb;
        s = x >>> 15;
        s = s * s;
        s = s >>> 7;
        s = s * h1;
        x = x - (s >>> 4);
        if (x < 0) x = 0;
        else if (x > 32'sd419430400) x = 32'sd419430400;
        s = ((x >>> 12) * 100) >>> 10;
        r.hum = s[13:0];
        return r;
    endfunction

    task automatic apb_write(logic [2:0] idx, logic [63:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TEMP_CALIB:    cal_t  = val[47:0];
            REG_PRESS_CALIB_A: cal_pa = val;
            REG_PRESS_CALIB_B: cal_pb = val;
            REG_PRESS_CALIB_C: cal_pc = val[15:0];
            REG_HUM_CALIB_A:   cal_ha = val[31:0];
            REG_HUM_CALIB_B:   cal_hb = val[39:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_words.size() == 0 && expected_comp.size() == 0 && !i_in_valid);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // typical datasheet-like calibration, used for realistic phases
    task automatic nominal_cal();
        apb_write(REG_TEMP_CALIB, 64'({16'd50, 16'd26435, 16'd27504}));
        apb_write(REG_PRESS_CALIB_A, {16'd2855, 16'd3024, -16'sd10685, 16'd36477});
        apb_write(REG_PRESS_CALIB_B, {-16'sd12000, 16'd15500, -16'sd7, 16'd140});
        apb_write(REG_PRESS_CALIB_C, 64'd6000);
        apb_write(REG_HUM_CALIB_A, 64'({8'd0, 16'd359, 8'd75}));
        apb_write(REG_HUM_CALIB_B, 64'({8'd30, 16'd50, 16'd330}));
    endtask

    task automatic random_cal();
        apb_write(REG_TEMP_CALIB, rnd64());
        apb_write(REG_PRESS_CALIB_A, rnd64());
        apb_write(REG_PRESS_CALIB_B, rnd64());
        apb_write(REG_PRESS_CALIB_C, rnd64());
        apb_write(REG_HUM_CALIB_A, rnd64());
        apb_write(REG_HUM_CALIB_B, rnd64());
    endtask

    task automatic push_word(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh);
        t_raw w;
        w = {rp, rt, rh};
        pending_words.push_back(w);
        expected_comp.push_back(compensate(w));
    endtask

    task automatic push_random(int n, bit realistic);
        for (int k = 0; k < n; k++) begin
            if (realistic)
                push_word(20'($urandom_range(200000, 600000)),
                          20'($urandom_range(400000, 600000)),
                          16'($urandom_range(20000, 40000)));
            else
                push_word(20'($urandom), 20'($urandom), 16'($urandom));
        end
    endtask

    // driver; the word on the bus stays at the front of the queue until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_stall) begin
            // hold the stalled word
        end else begin
            if (i_in_valid) void'(pending_words.pop_front());
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if ((pending_words.size() > 0) && !sender_pause) begin
                t_raw w;
                w = pending_words[0];
                i_in_valid        <= 1'b1;
                i_raw_pressure    <= w.rp;
                i_raw_temperature <= w.rt;
                i_raw_humidity    <= w.rh;
                send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall and long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_req && hold_left == 0) begin
            hold_left <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= (hold_left > 1);
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_out_stall <= 1'b1;
        end else if (o_out_valid && !i_out_stall && $urandom_range(0, 2) == 0) begin
            recv_gap <= $urandom_range(0, 11);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_comp.size() == 0) begin
                $display("%0t: unexpected word temp=%h press=%h pv=%b hum=%h", $time,
                         o_temperature_centi, o_pressure_pa, o_pressure_valid,
                         o_humidity_centi);
                failed = 1;
            end else begin
                t_comp e;
                e = expected_comp.pop_front();
                if (o_temperature_centi !== e.temp) begin
                    $display("%0t: temperature exp %h got %h", $time, e.temp,
                             o_temperature_centi);
                    failed = 1;
                end
                if (o_pressure_pa !== e.press) begin
                    $display("%0t: pressure exp %h got %h", $time, e.press, o_pressure_pa);
                    failed = 1;
                end
                if (o_pressure_valid !== e.pvalid) begin
                    $display("%0t: pressure_valid exp %b got %b", $time, e.pvalid,
                             o_pressure_valid);
                    failed = 1;
                end
                if (o_humidity_centi !== e.hum) begin
                    $display("%0t: humidity exp %h got %h", $time, e.hum, o_humidity_centi);
                    failed = 1;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (expected_comp.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        i_raw_pressure = '0; i_raw_temperature = '0; i_raw_humidity = '0;
        cal_t = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0; cal_ha = '0; cal_hb = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset calibration: divisor is zero, pressure invalid
        push_word(20'd0, 20'd0, 16'd0);
        push_word(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        drain();

        nominal_cal();
        push_word(20'd415148, 20'd519888, 16'd30000);
        push_word(20'd0, 20'd519888, 16'd0);
        push_word(20'hFFFFF, 20'd519888, 16'hFFFF);
        push_word(20'd415148, 20'd0, 16'd30000);
        push_word(20'd415148, 20'hFFFFF, 16'd30000);
        push_word(20'd415148, 20'd519888, 16'd60000);  // clamps high
        push_word(20'd415148, 20'd519888, 16'd1000);   // clamps low
        drain();

        // all-ones calibration words
        apb_write(REG_TEMP_CALIB, '1);
        apb_write(REG_PRESS_CALIB_A, '1);
        apb_write(REG_PRESS_CALIB_B, '1);
        apb_write(REG_PRESS_CALIB_C, '1);
        apb_write(REG_HUM_CALIB_A, '1);
        apb_write(REG_HUM_CALIB_B, '1);
        push_word(20'd0, 20'd0, 16'd0);
        push_word(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        push_word(20'h55555, 20'hAAAAA, 16'h5A5A);
        drain();

        // most-negative signed fields
        apb_write(REG_TEMP_CALIB, 64'h0000_8000_8000_FFFF);
        apb_write(REG_PRESS_CALIB_A, 64'h8000_8000_8000_FFFF);
        apb_write(REG_PRESS_CALIB_B, 64'h8000_8000_8000_8000);
        apb_write(REG_PRESS_CALIB_C, 64'h8000);
        apb_write(REG_HUM_CALIB_A, 64'h0000_0000_FF80_00FF);
        apb_write(REG_HUM_CALIB_B, 64'h0000_0080_8000_8000);
        push_word(20'd0, 20'd0, 16'd0);
        push_word(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        drain();

        // realistic traffic with a long receiver hold-off
        nominal_cal();
        push_random(200, 1);
        hold_req = 1;
        wait (hold_left > 0);
        hold_req = 0;
        wait (pending_words.size() < 100);
        // sender pause until all results have come
        sender_pause = 1;
        wait (expected_comp.size() == pending_words.size());
        sender_pause = 0;
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph % 2) random_cal(); else nominal_cal();
            push_random(100, ph % 3 != 2);
            drain();
        end

        if (!failed) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
